[sv/assert_macros.svh]
// Assertion macros for the checker module of this project.
// Depends on nothing; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion that is switched off while reset is high.
`define CHK_ASSERT(name, clk, rst, prop, msg) \
   name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Concurrent assertion that is checked during reset as well.
`define CHK_ASSERT_ALWAYS(name, clk, prop, msg) \
   name: assert property (@(posedge clk) prop) else $error(msg);

`endif

[sv/idalloc_pkg.sv]
// Package for the ID allocator: sizes, request codes and status codes.
// Depends on nothing.
`default_nettype none

package idalloc_pkg;

   localparam int IdBits     = 16;
   localparam int QueueDepth = 256;
   localparam int PtrBits    = $clog2(QueueDepth);
   localparam int CountBits  = $clog2(QueueDepth + 1);

   typedef enum logic {
      CMD_ALLOC   = 1'b0,
      CMD_RECLAIM = 1'b1
   } cmd_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_EXHAUSTED = 2'd1,
      ST_DROPPED   = 2'd2
   } status_type;

endpackage

`default_nettype wire

[sv/id_allocator_with_free_queue_top.sv]
// ID allocator with a FIFO of reclaimed IDs held in one synchronous memory.
// Depends on idalloc_pkg.
//
// Usage: the req channel carries one request word per handshake. An allocate
// returns the oldest reclaimed ID when the FIFO holds any, else the next fresh
// ID from a counter that starts at zero. A reclaim pushes req_id_in into the
// FIFO, or is dropped with a status when the FIFO is full. Once fresh IDs run
// out and the FIFO is empty, an allocate reports exhausted with ID zero.
// Every request gives exactly one rsp word, in order.
// The rsp word is valid in the cycle after acceptance. Throughput is one word
// per cycle while rsp_ready is high; the FIFO memory is written at the accept
// edge of a reclaim and read at the accept edge of an allocate, so a reclaim
// followed at once by an allocate of the same entry sees the written ID.
// A single output register holds the rsp word; req_ready is high when that
// register is empty or is being drained, so a stalled receiver stalls the
// sender after one word. Synchronous reset empties the FIFO, rewinds the
// fresh counter to zero and drops any pending rsp word; no clearing pass.
`default_nettype none

module id_allocator_with_free_queue_top (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_valid,
   output logic                                 req_ready,
   input  wire logic                            req_cmd,
   input  wire logic [idalloc_pkg::IdBits-1:0]  req_id_in,
   output logic                                 rsp_valid,
   input  wire logic                            rsp_ready,
   output logic [idalloc_pkg::IdBits-1:0]       rsp_id_out,
   output logic [1:0]                           rsp_status,
   output logic                                 rsp_from_queue
);
   import idalloc_pkg::*;

   logic [IdBits-1:0]    free_store [QueueDepth];

   logic [IdBits:0]      next_fresh_ff, next_fresh_in;
   logic [PtrBits-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [PtrBits-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [CountBits-1:0] count_ff, count_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   status_type           status_ff, status_in;
   logic                 from_queue_ff, from_queue_in;
   logic [IdBits-1:0]    fresh_id_ff, fresh_id_in;
   logic [IdBits-1:0]    rd_data_ff;

   logic accept, is_reclaim, empty, full, exhausted, push, pop, take_fresh;

   assign req_ready  = !rsp_valid_ff || rsp_ready;
   assign accept     = req_valid && req_ready;
   assign is_reclaim = (req_cmd == CMD_RECLAIM);
   assign empty      = (count_ff == '0);
   assign full       = (count_ff == CountBits'(QueueDepth));
   assign exhausted  = next_fresh_ff[IdBits];
   assign push       = accept && is_reclaim && !full;
   assign pop        = accept && !is_reclaim && !empty;
   assign take_fresh = accept && !is_reclaim && empty && !exhausted;

   always_comb begin
      next_fresh_in = next_fresh_ff;
      rd_ptr_in     = rd_ptr_ff;
      wr_ptr_in     = wr_ptr_ff;
      count_in      = count_ff;
      if (take_fresh) begin
         next_fresh_in = next_fresh_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrBits'(QueueDepth - 1)) ? '0 : rd_ptr_ff + 1'b1;
         count_in  = count_ff - 1'b1;
      end
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PtrBits'(QueueDepth - 1)) ? '0 : wr_ptr_ff + 1'b1;
         count_in  = count_ff + 1'b1;
      end
   end

   always_comb begin
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      status_in     = status_ff;
      from_queue_in = from_queue_ff;
      fresh_id_in   = fresh_id_ff;
      if (accept) begin
         rsp_valid_in  = 1'b1;
         from_queue_in = pop;
         fresh_id_in   = take_fresh ? next_fresh_ff[IdBits-1:0] : '0;
         if (is_reclaim) begin
            status_in = full ? ST_DROPPED : ST_OK;
         end else begin
            status_in = (empty && exhausted) ? ST_EXHAUSTED : ST_OK;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         next_fresh_ff <= '0;
         rd_ptr_ff     <= '0;
         wr_ptr_ff     <= '0;
         count_ff      <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         next_fresh_ff <= next_fresh_in;
         rd_ptr_ff     <= rd_ptr_in;
         wr_ptr_ff     <= wr_ptr_in;
         count_ff      <= count_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      status_ff     <= status_in;
      from_queue_ff <= from_queue_in;
      fresh_id_ff   <= fresh_id_in;
   end

   always_ff @(posedge clock) begin
      if (push) begin
         free_store[wr_ptr_ff] <= req_id_in;
      end
      if (pop) begin
         rd_data_ff <= free_store[rd_ptr_ff];
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_id_out     = from_queue_ff ? rd_data_ff : fresh_id_ff;
   assign rsp_status     = status_ff;
   assign rsp_from_queue = from_queue_ff;

endmodule

`default_nettype wire

[sv/idalloc_checker.sv]
// Port-level checker for the ID allocator, bound to the top level.
// Depends on idalloc_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module idalloc_checker (
   input wire logic                            clock,
   input wire logic                            reset,
   input wire logic                            req_valid,
   input wire logic                            req_ready,
   input wire logic                            rsp_valid,
   input wire logic                            rsp_ready,
   input wire logic [idalloc_pkg::IdBits-1:0]  rsp_id_out,
   input wire logic [1:0]                      rsp_status,
   input wire logic                            rsp_from_queue
);
   import idalloc_pkg::*;

   logic req_take;
   logic status_known;
   logic rsp_failed;
   logic rsp_clean;
   logic out_free;

   assign req_take     = req_valid && req_ready;
   assign status_known = (rsp_status == ST_OK) || (rsp_status == ST_EXHAUSTED)
                         || (rsp_status == ST_DROPPED);
   assign rsp_failed   = rsp_valid && (rsp_status != ST_OK);
   assign rsp_clean    = (rsp_id_out == '0) && !rsp_from_queue;
   assign out_free     = !rsp_valid || rsp_ready;

   `CHK_ASSERT_ALWAYS(a_idle_after_reset, clock, $past(reset) |-> !rsp_valid, "word after reset")
   `CHK_ASSERT(a_status_code, clock, reset, rsp_valid |-> status_known, "unknown status code")
   `CHK_ASSERT(a_fail_no_id, clock, reset, rsp_failed |-> rsp_clean, "failed word carries an ID")
   `CHK_ASSERT(a_ready_free, clock, reset, out_free |-> req_ready, "not ready with free output")
   `CHK_ASSERT(a_rsp_follows_req, clock, reset, req_take |=> rsp_valid, "no rsp for a word")

endmodule

bind id_allocator_with_free_queue_top idalloc_checker u_idalloc_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_valid),
   .req_ready      (req_ready),
   .rsp_valid      (rsp_valid),
   .rsp_ready      (rsp_ready),
   .rsp_id_out     (rsp_id_out),
   .rsp_status     (rsp_status),
   .rsp_from_queue (rsp_from_queue)
);

`default_nettype wire
